// ----- rtl/tlnf_pkg.sv -----
`default_nettype none

package tlnf_pkg;

  // Characters used in the rewritten stream.
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharI      = 8'h49;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharZero   = 8'h30;

  // The line number is kept in BCD so the back end can print it directly.
  localparam int unsigned NumDigits = 10;
  localparam int unsigned PfxWidth  = 6;

  typedef logic [NumDigits-1:0][3:0] bcd_t;
  typedef logic [3:0]                dig_idx_t;

  localparam bcd_t LineNumMax   = 40'h2147483647;
  localparam bcd_t LineNumFirst = 40'h0000000001;

  localparam int unsigned FifoDepthDef = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NUMBER_MODE = 2'd0,
    CFG_MARK_EOL    = 2'd1,
    CFG_SQUEEZE     = 2'd2,
    CFG_CARET_TAB   = 2'd3
  } cfg_idx_e;

  // Numbering modes; the fourth code numbers nothing.
  localparam logic [1:0] NumOff      = 2'd0;
  localparam logic [1:0] NumAll      = 2'd1;
  localparam logic [1:0] NumNonblank = 2'd2;

  // One command from the front end: an optional number prefix, then one or
  // two body bytes.
  typedef struct packed {
    logic     pfx;
    bcd_t     digits;
    dig_idx_t nd;
    logic     two;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PFX,
    ST_TAB,
    ST_B0,
    ST_B1
  } back_state_e;

endpackage

`default_nettype wire

// ----- rtl/text_line_number_filter.sv -----
`default_nettype none

// Line-numbering text filter. Raw text bytes enter on the s_axis channel,
// one byte per transfer; the rewritten bytes leave on the m_axis channel,
// with tlast marking the final output byte caused by each input byte. A
// byte may cause no output (a squeezed blank line), one byte, or up to
// thirteen (a number prefix of six or more columns plus a tab, then "$\n"
// or "^I"). Registers are written through the cfg channel, which is always
// ready: index 0 number mode, 1 show ends, 2 squeeze blank, 3 show tabs.
// The front end classifies each byte and updates the line state in the
// cycle of its transfer; it accepts one byte per cycle while the command
// queue has room. The back end emits one output byte per cycle while the
// receiver is ready, so a plain text stream flows at one byte per cycle. A
// byte passes through the command queue, the back end's command register and
// the output register before it appears on m_axis. When the receiver stalls,
// the output register holds its byte, the queue fills and s_axis_tready_o
// falls. Reset clears the registers to zero, returns the line number to one
// and the line state to the start of a line, and empties the queue.
module text_line_number_filter import tlnf_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [1:0] cfg_data_i,
  // Input stream.
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  // Output stream.
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // last_of_run
);

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  tlnf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Short command queue decoupling classification from byte emission.
  tlnf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  tlnf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (pop_cmd),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

// ----- rtl/tlnf_front.sv -----
`default_nettype none

module tlnf_front import tlnf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [1:0] number_mode_q;
  logic       mark_eol_q, squeeze_q, caret_tab_q;
  logic       at_start_q, at_start_d;
  logic [1:0] blank_run_q, blank_run_d;
  bcd_t       line_num_q, line_num_d, line_num_inc;
  dig_idx_t   nd;
  logic       accept, is_nl, is_tab, squeezed, pfx;

  assign s_axis_tready_o = !full_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_nl  = (s_axis_tdata_i == CharNl);
  assign is_tab = (s_axis_tdata_i == CharTab);

  // BCD increment (saturation at LineNumMax is applied below): a digit steps when every digit below it is nine.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < int'(NumDigits); i++) begin
      if (carry) begin
        line_num_inc[i] = (line_num_q[i] == 4'd9) ? 4'd0 : line_num_q[i] + 4'd1;
      end else begin
        line_num_inc[i] = line_num_q[i];
      end
      carry = carry && (line_num_q[i] == 4'd9);
    end
  end

  // Count of significant digits, at least one.
  always_comb begin
    nd = dig_idx_t'(1);
    for (int i = 0; i < int'(NumDigits); i++) begin
      if (line_num_q[i] != 4'd0) begin
        nd = dig_idx_t'(i + 1);
      end
    end
  end

  always_comb begin
    if (!at_start_q) begin
      blank_run_d = blank_run_q;
    end else if (is_nl) begin
      blank_run_d = (blank_run_q == 2'd3) ? 2'd3 : blank_run_q + 2'd1;
    end else begin
      blank_run_d = 2'd0;
    end
    squeezed = at_start_q && is_nl && squeeze_q && (blank_run_d > 2'd1);
    // A squeezed newline prints nothing, so it takes no number either.
    pfx = at_start_q && !squeezed &&
          ((number_mode_q == NumAll) ||
           ((number_mode_q == NumNonblank) && !is_nl));
    at_start_d = squeezed ? at_start_q : is_nl;
    line_num_d = (pfx && (line_num_q != LineNumMax)) ? line_num_inc : line_num_q;
  end

  always_comb begin
    cmd_o.pfx    = pfx;
    cmd_o.digits = line_num_q;
    cmd_o.nd     = nd;
    if (is_nl) begin
      cmd_o.two = mark_eol_q;
      cmd_o.b0  = mark_eol_q ? CharDollar : CharNl;
      cmd_o.b1  = CharNl;
    end else if (is_tab && caret_tab_q) begin
      cmd_o.two = 1'b1;
      cmd_o.b0  = CharCaret;
      cmd_o.b1  = CharI;
    end else begin
      cmd_o.two = 1'b0;
      cmd_o.b0  = s_axis_tdata_i;
      cmd_o.b1  = CharI;
    end
  end

  assign push_o = accept && !squeezed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_mode_q <= NumOff;
      mark_eol_q    <= 1'b0;
      squeeze_q     <= 1'b0;
      caret_tab_q   <= 1'b0;
      at_start_q    <= 1'b1;
      blank_run_q   <= 2'd0;
      line_num_q    <= LineNumFirst;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_NUMBER_MODE: number_mode_q <= cfg_data_i;
          CFG_MARK_EOL:    mark_eol_q    <= cfg_data_i[0];
          CFG_SQUEEZE:     squeeze_q     <= cfg_data_i[0];
          CFG_CARET_TAB:   caret_tab_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        at_start_q  <= at_start_d;
        blank_run_q <= blank_run_d;
        line_num_q  <= line_num_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_nl) |=> !at_start_q)
    else $error("line start flag kept after a non-newline byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pfx) |=> $stable(line_num_q))
    else $error("line number moved without a prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && pfx) |-> at_start_q)
    else $error("prefix requested in the middle of a line");

endmodule

`default_nettype wire

// ----- rtl/tlnf_fifo.sv -----
`default_nettype none

module tlnf_fifo import tlnf_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("command queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full command queue");

endmodule

`default_nettype wire

// ----- rtl/tlnf_back.sv -----
`default_nettype none

module tlnf_back import tlnf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  input  wire logic       empty_i,
  output logic            pop_o,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,
  output logic            m_axis_tlast_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  dig_idx_t    dig_q, dig_d;
  logic        m_valid_q, m_valid_d;
  logic [7:0]  m_data_q;
  logic        m_last_q;
  logic [7:0]  out_byte;
  logic        out_last, advance, done, load;

  // Index of the leftmost printed column, counted from the units digit.
  function automatic dig_idx_t first_col(input dig_idx_t nd);
    dig_idx_t w;
    w = (nd > dig_idx_t'(PfxWidth)) ? nd : dig_idx_t'(PfxWidth);
    return w - dig_idx_t'(1);
  endfunction

  // Byte for the current step.
  always_comb begin
    out_byte = cmd_q.b0;
    out_last = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_PFX: begin
        if (dig_q >= cmd_q.nd) begin
          out_byte = CharSpace;
        end else begin
          out_byte = CharZero + {4'h0, cmd_q.digits[dig_q]};
        end
      end
      ST_TAB: out_byte = CharTab;
      ST_B0: begin
        out_byte = cmd_q.b0;
        out_last = !cmd_q.two;
      end
      ST_B1: begin
        out_byte = cmd_q.b1;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign advance = (state_q != ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign done    = advance && out_last;
  assign load    = ((state_q == ST_IDLE) || done) && !empty_i;
  assign pop_o   = load;

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cmd_d   = cmd_q;
    if (load) begin
      cmd_d   = cmd_i;
      state_d = cmd_i.pfx ? ST_PFX : ST_B0;
      dig_d   = first_col(cmd_i.nd);
    end else if (done) begin
      state_d = ST_IDLE;
    end else if (advance) begin
      unique case (state_q)
        ST_PFX: begin
          if (dig_q == '0) begin
            state_d = ST_TAB;
          end else begin
            dig_d = dig_q - dig_idx_t'(1);
          end
        end
        ST_TAB:  state_d = ST_B0;
        ST_B0:   state_d = ST_B1;
        ST_B1:   state_d = ST_IDLE;
        ST_IDLE: state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    if (advance) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    dig_q <= dig_d;
    if (advance) begin
      m_data_q <= out_byte;
      m_last_q <= out_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PFX || state_q == ST_TAB) |-> cmd_q.pfx)
    else $error("prefix step for a command without prefix");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_B1) |-> cmd_q.two)
    else $error("second body byte for a one-byte command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PFX) |-> (dig_q < dig_idx_t'(NumDigits)))
    else $error("digit column out of range");

endmodule

`default_nettype wire
